// File: rtl/core/mdd_pkg.sv
// Shared types and constants for the mouse drag detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mdd_pkg;

   localparam int COORD_BITS    = 16;
   localparam int DELTA_BITS    = 16;
   localparam int VEC_BITS      = COORD_BITS + 1;
   localparam int MAG_BITS      = COORD_BITS;
   localparam int FRAME_BITS    = 24;
   localparam int THR_BITS      = 10;
   localparam int THR_SQ_BITS   = 2 * THR_BITS;
   localparam int DIST_BITS     = 2 * MAG_BITS + 1;
   localparam int IN_DATA_BITS  = 72;
   localparam int OUT_DATA_BITS = 128;
   localparam int CSR_ADDR_BITS = 1;

   localparam logic [THR_SQ_BITS-1:0] THR_SQ_RESET = THR_SQ_BITS'(25);

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_THRESHOLD     = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_USE_RAW_MOUSE = 1'b1;

   // Item kinds carried on tuser
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_RAW  = 1'b1;

   typedef struct packed {
      logic dragging;
      logic started;
      logic ended;
   } mdd_status_type;

endpackage

// File: rtl/core/mdd_button.sv
// Per-button drag state machine: candidate arming, threshold test, start and release.
// Depends on mdd_pkg.
`timescale 1ns / 1ps

module mdd_button
   import mdd_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          has_focus,
   input  logic                          btn_now,
   input  logic                          btn_before,
   input  logic signed [COORD_BITS-1:0]  cur_x,
   input  logic signed [COORD_BITS-1:0]  cur_y,
   input  logic        [THR_SQ_BITS-1:0] thr_sq,
   output mdd_status_type                status,
   output logic signed [VEC_BITS-1:0]    vec_x,
   output logic signed [VEC_BITS-1:0]    vec_y
);

   logic                         cand_ff, cand_in;
   logic                         drag_ff, drag_in;
   logic signed [COORD_BITS-1:0] press_x_ff, press_y_ff;
   logic signed [COORD_BITS-1:0] start_x_ff, start_y_ff;
   logic signed [COORD_BITS-1:0] start_x_in, start_y_in;

   logic                         press_edge, cand_eff, over_thr;
   logic signed [COORD_BITS-1:0] px_eff, py_eff;
   logic signed [VEC_BITS-1:0]   dx, dy, ndx, ndy;
   logic        [MAG_BITS-1:0]   ax, ay;
   logic        [DIST_BITS-1:0]  dist_sq;

   assign press_edge = btn_now & ~btn_before;
   assign cand_eff   = cand_ff | press_edge;
   assign px_eff     = press_edge ? cur_x : press_x_ff;
   assign py_eff     = press_edge ? cur_y : press_y_ff;

   // squared distance from the press point
   assign dx   = VEC_BITS'(cur_x) - VEC_BITS'(px_eff);
   assign dy   = VEC_BITS'(cur_y) - VEC_BITS'(py_eff);
   assign ndx  = -dx;
   assign ndy  = -dy;
   assign ax   = dx[VEC_BITS-1] ? ndx[MAG_BITS-1:0] : dx[MAG_BITS-1:0];
   assign ay   = dy[VEC_BITS-1] ? ndy[MAG_BITS-1:0] : dy[MAG_BITS-1:0];
   assign dist_sq = DIST_BITS'((2 * MAG_BITS)'(ax) * (2 * MAG_BITS)'(ax))
                  + DIST_BITS'((2 * MAG_BITS)'(ay) * (2 * MAG_BITS)'(ay));
   assign over_thr = dist_sq >= DIST_BITS'(thr_sq);

   always_comb begin
      cand_in    = cand_ff;
      drag_in    = drag_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      status     = '0;
      priority if (!has_focus) begin
         status.ended = drag_ff;
         drag_in      = 1'b0;
         cand_in      = 1'b0;
      end else if (!drag_ff && btn_now) begin
         cand_in = cand_eff;
         if (cand_eff && over_thr) begin
            status.started = 1'b1;
            drag_in        = 1'b1;
            start_x_in     = px_eff;
            start_y_in     = py_eff;
         end
      end else if (!btn_now && btn_before) begin
         status.ended = drag_ff;
         drag_in      = 1'b0;
         cand_in      = 1'b0;
      end else begin
         cand_in = cand_eff;
      end
      status.dragging = drag_in;
   end

   assign vec_x = VEC_BITS'(cur_x) - VEC_BITS'(start_x_in);
   assign vec_y = VEC_BITS'(cur_y) - VEC_BITS'(start_y_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff    <= 1'b0;
         drag_ff    <= 1'b0;
         press_x_ff <= '0;
         press_y_ff <= '0;
         start_x_ff <= '0;
         start_y_ff <= '0;
      end else if (step) begin
         cand_ff    <= cand_in;
         drag_ff    <= drag_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         if (has_focus && press_edge) begin
            press_x_ff <= cur_x;
            press_y_ff <= cur_y;
         end
      end
   end

endmodule

// File: rtl/core/mouse_drag_detector_top.sv
// Mouse drag detector top level: input register, frame delta, raw sums, result register.
// Depends on mdd_pkg and mdd_button.
`timescale 1ns / 1ps

// Frame-based drag detector for a left and a right button. Two kinds of
// transaction arrive on the req_ channel, told apart by req_tuser: a raw
// motion transaction (tuser = 1) adds raw_dx/raw_dy into two saturating
// ACCUM_BITS-wide sums and produces no result; a frame tick (tuser = 0)
// samples focus, button levels and cursor, runs both drag machines and
// produces exactly one rsp_ transaction. A drag starts once the squared
// distance from the press point reaches the threshold squared and ends on
// release or on loss of focus. Throughput is one transaction per clock,
// under any mix of ticks and raw motion while rsp_tready is high; a tick
// goes through the input register, then the result register, to rsp_.
// The critical path is the squared-distance test: two 16x16 squares, an
// add and a compare per button. The result register holds a finished
// result while the next transaction is taken into the input register, so
// only a stalled rsp_ side with both stages full holds off req_tready.
// No clearing pass is needed after reset. Write csr_ registers only while
// the block is idle; the threshold is squared at write time.

module mouse_drag_detector_top
   import mdd_pkg::*;
#(
   parameter int ACCUM_BITS = 24
)(
   input  logic                     clock,
   input  logic                     reset,
   // fields from bit 0: has_focus, left_button, right_button,
   // cursor_x[15:0], cursor_y[15:0], raw_dx[15:0], raw_dy[15:0], zero pad
   input  logic [IN_DATA_BITS-1:0]  req_tdata,
   input  logic                     req_tuser,   // mode: 0 frame tick, 1 raw delta
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // fields from bit 0: frame_dx[23:0], frame_dy[23:0], left_dragging,
   // left_started, left_ended, right_dragging, right_started, right_ended,
   // left_vec_x[16:0], left_vec_y[16:0], right_vec_x[16:0], right_vec_y[16:0],
   // zero pad
   output logic [OUT_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [THR_BITS-1:0]      csr_wdata
);

   localparam int SUM_BITS  = ACCUM_BITS + 1;
   localparam int WIDE_BITS = (ACCUM_BITS > FRAME_BITS) ? ACCUM_BITS : FRAME_BITS;
   localparam int PAY_BITS  = 2 * FRAME_BITS + 6 + 4 * VEC_BITS;

   // configuration
   logic [THR_SQ_BITS-1:0] thr_sq_ff;
   logic                   use_raw_ff;

   // input register
   logic                    in_valid_ff;
   logic                    in_mode_ff;
   logic [IN_DATA_BITS-1:0] in_data_ff;

   // block state
   logic [1:0]                   btn_now_ff;
   logic signed [COORD_BITS-1:0] last_x_ff, last_y_ff;
   logic signed [ACCUM_BITS-1:0] acc_x_ff, acc_y_ff;
   logic signed [ACCUM_BITS-1:0] acc_x_in, acc_y_in;

   // result register
   logic                    out_valid_ff;
   logic [PAY_BITS-1:0]     out_pay_ff, out_pay_in;

   // unpacked fields of the held transaction
   logic                         f_focus, f_left, f_right;
   logic signed [COORD_BITS-1:0] f_cx, f_cy;
   logic signed [DELTA_BITS-1:0] f_rdx, f_rdy;

   logic fire, tick_fire, raw_fire;
   logic [1:0] btn_in;

   mdd_status_type              st_left, st_right;
   logic signed [VEC_BITS-1:0]  lvx, lvy, rvx, rvy;

   logic signed [SUM_BITS-1:0]   sum_x, sum_y;
   logic signed [VEC_BITS-1:0]   cdx, cdy;
   logic signed [WIDE_BITS-1:0]  wide_x, wide_y, frame_max, frame_min;
   logic signed [FRAME_BITS-1:0] raw_fx, raw_fy, fdx, fdy;

   assign f_focus = in_data_ff[0];
   assign f_left  = in_data_ff[1];
   assign f_right = in_data_ff[2];
   assign f_cx    = in_data_ff[3 +: COORD_BITS];
   assign f_cy    = in_data_ff[3 + COORD_BITS +: COORD_BITS];
   assign f_rdx   = in_data_ff[3 + 2 * COORD_BITS +: DELTA_BITS];
   assign f_rdy   = in_data_ff[3 + 2 * COORD_BITS + DELTA_BITS +: DELTA_BITS];

   // raw motion never needs the result register, a tick needs it free or draining
   assign fire       = in_valid_ff && (in_mode_ff == MODE_RAW || !out_valid_ff || rsp_tready);
   assign tick_fire  = fire && (in_mode_ff == MODE_TICK);
   assign raw_fire   = fire && (in_mode_ff == MODE_RAW);
   assign req_tready = !in_valid_ff || fire;

   assign btn_in = f_focus ? {f_right, f_left} : 2'b00;

   mdd_button u_left (
      .clock      (clock),
      .reset      (reset),
      .step       (tick_fire),
      .has_focus  (f_focus),
      .btn_now    (btn_in[0]),
      .btn_before (btn_now_ff[0]),
      .cur_x      (f_cx),
      .cur_y      (f_cy),
      .thr_sq     (thr_sq_ff),
      .status     (st_left),
      .vec_x      (lvx),
      .vec_y      (lvy)
   );

   mdd_button u_right (
      .clock      (clock),
      .reset      (reset),
      .step       (tick_fire),
      .has_focus  (f_focus),
      .btn_now    (btn_in[1]),
      .btn_before (btn_now_ff[1]),
      .cur_x      (f_cx),
      .cur_y      (f_cy),
      .thr_sq     (thr_sq_ff),
      .status     (st_right),
      .vec_x      (rvx),
      .vec_y      (rvy)
   );

   // saturating raw sums
   assign sum_x = SUM_BITS'(acc_x_ff) + SUM_BITS'(f_rdx);
   assign sum_y = SUM_BITS'(acc_y_ff) + SUM_BITS'(f_rdy);

   always_comb begin
      acc_x_in = sum_x[ACCUM_BITS-1:0];
      acc_y_in = sum_y[ACCUM_BITS-1:0];
      if (sum_x[SUM_BITS-1] != sum_x[SUM_BITS-2])
         acc_x_in = sum_x[SUM_BITS-1] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                                      : {1'b0, {(ACCUM_BITS-1){1'b1}}};
      if (sum_y[SUM_BITS-1] != sum_y[SUM_BITS-2])
         acc_y_in = sum_y[SUM_BITS-1] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                                      : {1'b0, {(ACCUM_BITS-1){1'b1}}};
   end

   // raw sums clamped into the frame delta range
   assign frame_max = {{(WIDE_BITS-FRAME_BITS+1){1'b0}}, {(FRAME_BITS-1){1'b1}}};
   assign frame_min = ~frame_max;
   assign wide_x    = WIDE_BITS'(acc_x_ff);
   assign wide_y    = WIDE_BITS'(acc_y_ff);

   always_comb begin
      raw_fx = wide_x[FRAME_BITS-1:0];
      raw_fy = wide_y[FRAME_BITS-1:0];
      if (wide_x > frame_max) raw_fx = frame_max[FRAME_BITS-1:0];
      if (wide_x < frame_min) raw_fx = frame_min[FRAME_BITS-1:0];
      if (wide_y > frame_max) raw_fy = frame_max[FRAME_BITS-1:0];
      if (wide_y < frame_min) raw_fy = frame_min[FRAME_BITS-1:0];
   end

   assign cdx = VEC_BITS'(f_cx) - VEC_BITS'(last_x_ff);
   assign cdy = VEC_BITS'(f_cy) - VEC_BITS'(last_y_ff);

   always_comb begin
      priority if (!f_focus) begin
         fdx = '0;
         fdy = '0;
      end else if (use_raw_ff) begin
         fdx = raw_fx;
         fdy = raw_fy;
      end else begin
         fdx = FRAME_BITS'(cdx);
         fdy = FRAME_BITS'(cdy);
      end
   end

   assign out_pay_in = {rvy, rvx, lvy, lvx,
                        st_right.ended, st_right.started, st_right.dragging,
                        st_left.ended, st_left.started, st_left.dragging,
                        fdy, fdx};

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_DATA_BITS'(out_pay_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_sq_ff  <= THR_SQ_RESET;
         use_raw_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_THRESHOLD:     thr_sq_ff  <= THR_SQ_BITS'(csr_wdata) * THR_SQ_BITS'(csr_wdata);
            CSR_USE_RAW_MOUSE: use_raw_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   // block state
   always_ff @(posedge clock) begin
      if (reset) begin
         btn_now_ff <= '0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         acc_x_ff   <= '0;
         acc_y_ff   <= '0;
      end else if (raw_fire) begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
      end else if (tick_fire) begin
         btn_now_ff <= btn_in;
         last_x_ff  <= f_cx;
         last_y_ff  <= f_cy;
         acc_x_ff   <= '0;
         acc_y_ff   <= '0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (tick_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_fire) begin
         out_pay_ff <= out_pay_in;
      end
   end

endmodule

// File: rtl/core/mdd_checker.sv
// Port-level checks for the mouse drag detector, bound to the top level.
// Depends on mdd_pkg and mouse_drag_detector_top.
`timescale 1ns / 1ps

module mdd_checker
   import mdd_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic [OUT_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready
);

   localparam int FLAG_LSB = 2 * FRAME_BITS;

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // nothing is offered the cycle after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // left: a start leaves the drag running, an end leaves it stopped
   a_left_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[FLAG_LSB + 1] || rsp_tdata[FLAG_LSB])
                  && (!rsp_tdata[FLAG_LSB + 2] || !rsp_tdata[FLAG_LSB]))
      else $error("left drag flags inconsistent");

   a_right_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[FLAG_LSB + 4] || rsp_tdata[FLAG_LSB + 3])
                  && (!rsp_tdata[FLAG_LSB + 5] || !rsp_tdata[FLAG_LSB + 3]))
      else $error("right drag flags inconsistent");

endmodule

bind mouse_drag_detector_top mdd_checker u_mdd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
